[rtl/delimited_frame_receiver_defines.svh]
// Assertion macros for the frame receiver.
`ifndef DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property checked on every rising clock edge outside reset.
`define DFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("frame receiver check failed");

// Implication: the consequent must hold in the same cycle as the antecedent.
`define DFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

`else

`define DFR_ASSERT(lbl, clk, rstn, prop)
`define DFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/dfr_pkg.sv]
package dfr_pkg;

  // Buffer geometry
  localparam int BufferDepth = 128;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam int CntW        = $clog2(BufferDepth + 1);

  // Register reset values and idle tick limit
  localparam logic [7:0]  StartMarkerRst = 8'h68;
  localparam logic [7:0]  EndMarkerRst   = 8'h16;
  localparam logic [15:0] IdleTimeoutRst = 16'd50;
  localparam logic [15:0] IdleTicksMax   = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] RegStartMarker = 2'd0;
  localparam logic [1:0] RegEndMarker   = 2'd1;
  localparam logic [1:0] RegIdleTimeout = 2'd2;

  typedef enum logic [1:0] {
    OpByte    = 2'd0,
    OpTick    = 2'd1,
    OpRestart = 2'd2,
    OpRead    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseEnd     = 2'd1,
    CauseTimeout = 2'd2
  } cause_e;

  // Frame status after a transaction
  typedef struct packed {
    logic            ready;
    cause_e          cause;
    logic [CntW-1:0] length;
  } status_t;

  // Buffer write command
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

endpackage

[rtl/dfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dfr_ctrl.sv]
// Frame state: byte count, ready flag, cause, idle ticks, markers, and a
// copy of the first three buffer bytes for the start marker and length check.
module dfr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_addr_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         accept_i,
  input  dfr_pkg::op_e                 op_i,
  input  logic [7:0]                   rx_byte_i,
  output dfr_pkg::ram_wr_t             ram_wr_o,
  output dfr_pkg::status_t             status_o
);

  logic [7:0]                   start_marker_q;
  logic [7:0]                   end_marker_q;
  logic [15:0]                  idle_timeout_q;

  logic [dfr_pkg::CntW-1:0]     count_q, count_d;
  logic                         ready_q, ready_d;
  dfr_pkg::cause_e              cause_q, cause_d;
  logic [15:0]                  ticks_q, ticks_d;

  // Header bytes at positions 0..2, kept in flops beside the RAM
  logic [7:0]                   hdr0_q, hdr1_q, hdr2_q;
  logic [7:0]                   hdr0_d, hdr1_d, hdr2_d;

  logic [dfr_pkg::AddrW-1:0]    wpos;
  logic [dfr_pkg::CntW-1:0]     new_count;
  logic                         store;

  // Write position: wrap to zero when full
  assign wpos = (count_q >= dfr_pkg::CntW'(dfr_pkg::BufferDepth)) ?
                '0 : dfr_pkg::AddrW'(count_q);
  assign new_count = dfr_pkg::CntW'(wpos) + dfr_pkg::CntW'(1);
  assign store = accept_i && (op_i == dfr_pkg::OpByte) && !ready_q;

  always_comb begin
    count_d = count_q;
    ready_d = ready_q;
    cause_d = cause_q;
    ticks_d = ticks_q;
    hdr0_d  = hdr0_q;
    hdr1_d  = hdr1_q;
    hdr2_d  = hdr2_q;
    if (accept_i) begin
      case (op_i)
        dfr_pkg::OpByte: begin
          if (!ready_q) begin
            ticks_d = '0;
            count_d = new_count;
            if (wpos == dfr_pkg::AddrW'(0)) hdr0_d = rx_byte_i;
            if (wpos == dfr_pkg::AddrW'(1)) hdr1_d = rx_byte_i;
            if (wpos == dfr_pkg::AddrW'(2)) hdr2_d = rx_byte_i;
            // Completion on end marker with matching start marker and declared length
            if ((rx_byte_i == end_marker_q) && (hdr0_d == start_marker_q) &&
                ({hdr1_d, hdr2_d} == 16'(new_count))) begin
              ready_d = 1'b1;
              cause_d = dfr_pkg::CauseEnd;
            end
          end
        end
        dfr_pkg::OpTick: begin
          if (ticks_q != dfr_pkg::IdleTicksMax) ticks_d = ticks_q + 16'd1;
          if (!ready_q && (count_q != '0) && (ticks_d > idle_timeout_q)) begin
            ready_d = 1'b1;
            cause_d = dfr_pkg::CauseTimeout;
          end
        end
        dfr_pkg::OpRestart: begin
          count_d = '0;
          ready_d = 1'b0;
          cause_d = dfr_pkg::CauseNone;
        end
        default: ;
      endcase
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      ready_q        <= 1'b0;
      cause_q        <= dfr_pkg::CauseNone;
      ticks_q        <= '0;
      start_marker_q <= dfr_pkg::StartMarkerRst;
      end_marker_q   <= dfr_pkg::EndMarkerRst;
      idle_timeout_q <= dfr_pkg::IdleTimeoutRst;
    end else begin
      count_q <= count_d;
      ready_q <= ready_d;
      cause_q <= cause_d;
      ticks_q <= ticks_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          dfr_pkg::RegStartMarker: start_marker_q <= cfg_wdata_i[7:0];
          dfr_pkg::RegEndMarker:   end_marker_q   <= cfg_wdata_i[7:0];
          dfr_pkg::RegIdleTimeout: idle_timeout_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Header copy is payload only
  always_ff @(posedge clk_i) begin
    hdr0_q <= hdr0_d;
    hdr1_q <= hdr1_d;
    hdr2_q <= hdr2_d;
  end

  assign ram_wr_o.en   = store;
  assign ram_wr_o.addr = wpos;
  assign ram_wr_o.data = rx_byte_i;

  assign status_o.ready  = ready_d;
  assign status_o.cause  = cause_d;
  assign status_o.length = count_d;

endmodule

[rtl/delimited_frame_receiver.sv]
// Pipeline: two register stages, stage 1 and the output register; a result is
// registered in stage 1 and then in the output register before it is presented.
// Throughput: one transaction per cycle unless the output stalls; the buffer RAM
// takes one write (received byte) or one read (buffer read) per cycle, read data
// registered. Reset clears count, ready flag, cause, idle ticks and the pipeline
// valids, and loads the marker and timeout registers with their defaults. Buffer
// contents are undefined until written; there is no clearing pass.
`include "delimited_frame_receiver_defines.svh"

module delimited_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] read_data, [8] frame_ready,
                                      // [10:9] ready_cause, [18:11] frame_length
);

  logic                       accept;
  logic                       out_free;
  logic                       advance;
  dfr_pkg::op_e               op;
  logic [7:0]                 rx_byte;
  logic [6:0]                 read_index;

  dfr_pkg::ram_wr_t           ram_wr;
  dfr_pkg::status_t           status;
  logic                       rd_en;
  logic                       rd_hit;
  logic [7:0]                 ram_rdata;

  // Stage 1: RAM read in flight
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_hit_q;
  dfr_pkg::status_t           s1_status_q;

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_data_q;
  dfr_pkg::status_t           out_status_q;

  assign op         = dfr_pkg::op_e'(s_axis_tuser);
  assign rx_byte    = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[14:8];

  // Handshake: stage 1 drains whenever the output register is free
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (op),
    .rx_byte_i   (rx_byte),
    .ram_wr_o    (ram_wr),
    .status_o    (status)
  );

  // Reads beyond the stored length return zero
  assign rd_hit = (16'(read_index) < 16'(status.length));
  assign rd_en  = accept && (op == dfr_pkg::OpRead) && rd_hit;

  dfr_ram #(
    .Width (8),
    .Depth (dfr_pkg::BufferDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (dfr_pkg::AddrW'(read_index)),
    .rdata_o (ram_rdata)
  );

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q    <= rd_en;
      s1_status_q <= status;
    end
    if (advance) begin
      out_data_q   <= s1_hit_q ? ram_rdata : 8'd0;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, 8'(out_status_q.length), out_status_q.cause,
                          out_status_q.ready, out_data_q};

  // Checks
  `DFR_ASSERT_IMPL(a_cause_matches_ready, clk_i, rst_ni, m_axis_tvalid,
                   (m_axis_tdata[8] == (m_axis_tdata[10:9] != 2'd0)))
  `DFR_ASSERT_IMPL(a_length_in_range, clk_i, rst_ni, m_axis_tvalid,
                   (out_status_q.length <= dfr_pkg::CntW'(dfr_pkg::BufferDepth)))
  `DFR_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, (s1_valid_q && !out_free),
                   !s_axis_tready)
  `DFR_ASSERT(a_ram_one_port_op, clk_i, rst_ni, !(ram_wr.en && rd_en))

endmodule
